// ===== rtl/xtok_pkg.sv =====
// ----------------------------------------------------------------------------
// xtok_pkg: shared types and constants of the XML tag tokenizer
// Grammar positions, event codes, character constants and the item formats
// passed between the step logic, the result queue and the checker.
// ----------------------------------------------------------------------------
package xtok_pkg;

  typedef enum logic [3:0] {
    ST_TOP,
    ST_TAG_WAIT,
    ST_TAG_NAME,
    ST_ATTR_WAIT,
    ST_ATTR_NAME,
    ST_EQ_WAIT,
    ST_VAL_WAIT,
    ST_VAL,
    ST_END_WAIT,
    ST_END_NAME,
    ST_CLOSE_WAIT,
    ST_PI,
    ST_PI_QUOTE
  } pstate_t;

  // Pending lookahead symbol
  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_LT,
    HELD_SLASH,
    HELD_QM
  } held_t;

  typedef enum logic [3:0] {
    EV_NAME,
    EV_ANAME,
    EV_VALUE,
    EV_ADONE,
    EV_START,
    EV_END,
    EV_EMPTY,
    EV_ERROR,
    EV_INEND
  } event_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result queue depth; one item may push two results
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    pstate_t pstate;
    held_t   held;
    logic    in_prolog;
    logic    error_flag;
    logic    first_symbol;
  } tok_state_t;

  typedef struct packed {
    event_t     code;
    logic [7:0] ch;
    logic       last;
  } result_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ===== rtl/xtok_step.sv =====
// ----------------------------------------------------------------------------
// xtok_step: one-byte transition of the tag tokenizer
// Combinational next state and up to two result items for one input byte.
// ----------------------------------------------------------------------------
module xtok_step
  import xtok_pkg::*;
(
  input  tok_state_t  cur,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output tok_state_t  nxt,
  output logic [1:0]  count,
  output result_t     r0,
  output result_t     r1
);

  typedef struct packed {
    pstate_t    st;
    held_t      held;
    logic       fail;
    logic       again;
    logic       ev;
    event_t     code;
    logic [7:0] ch;
  } pass_t;

  // One grammar pass over the current position
  function automatic pass_t run_pass(pstate_t st, logic [7:0] b);
    pass_t p;
    p = '{st: st, held: HELD_NONE, fail: 1'b0, again: 1'b0, ev: 1'b0,
          code: EV_NAME, ch: 8'h00};
    case (st)
      ST_TOP: begin
        if (b == CH_LT) p.held = HELD_LT;
        else if (!is_blank(b)) p.fail = 1'b1;
      end
      ST_TAG_WAIT, ST_END_WAIT: begin
        if (is_letter(b)) begin
          p.ev = 1'b1; p.code = EV_NAME; p.ch = b;
          p.st = (st == ST_TAG_WAIT) ? ST_TAG_NAME : ST_END_NAME;
        end else if (!is_blank(b)) begin
          p.fail = 1'b1;
        end
      end
      ST_TAG_NAME, ST_END_NAME: begin
        if (is_letter(b)) begin
          p.ev = 1'b1; p.code = EV_NAME; p.ch = b;
        end else begin
          p.st = (st == ST_TAG_NAME) ? ST_ATTR_WAIT : ST_CLOSE_WAIT;
          p.again = 1'b1;
        end
      end
      ST_ATTR_WAIT: begin
        if (is_letter(b)) begin
          p.ev = 1'b1; p.code = EV_ANAME; p.ch = b;
          p.st = ST_ATTR_NAME;
        end else if (b == CH_GT) begin
          p.ev = 1'b1; p.code = EV_START;
          p.st = ST_TOP;
        end else if (b == CH_SLASH) begin
          p.held = HELD_SLASH;
        end else if (!is_blank(b)) begin
          p.fail = 1'b1;
        end
      end
      ST_ATTR_NAME: begin
        if (is_letter(b)) begin
          p.ev = 1'b1; p.code = EV_ANAME; p.ch = b;
        end else begin
          p.st = ST_EQ_WAIT;
          p.again = 1'b1;
        end
      end
      ST_EQ_WAIT: begin
        if (b == CH_EQ) p.st = ST_VAL_WAIT;
        else if (!is_blank(b)) p.fail = 1'b1;
      end
      ST_VAL_WAIT: begin
        if (b == CH_QUOTE) p.st = ST_VAL;
        else if (!is_blank(b)) p.fail = 1'b1;
      end
      ST_VAL: begin
        p.ev = 1'b1;
        if (b == CH_QUOTE) begin
          p.code = EV_ADONE;
          p.st = ST_ATTR_WAIT;
        end else begin
          p.code = EV_VALUE; p.ch = b;
        end
      end
      ST_CLOSE_WAIT: begin
        if (b == CH_GT) begin
          p.ev = 1'b1; p.code = EV_END;
          p.st = ST_TOP;
        end else if (!is_blank(b)) begin
          p.fail = 1'b1;
        end
      end
      ST_PI: begin
        if (b == CH_QUOTE) p.st = ST_PI_QUOTE;
        else if (b == CH_QM) p.held = HELD_QM;
      end
      ST_PI_QUOTE: begin
        if (b == CH_QUOTE) p.st = ST_PI;
      end
      default: p.fail = 1'b1;
    endcase
    return p;
  endfunction

  result_t    ev [2];
  pass_t      p1;
  pass_t      p2;
  logic       fail;
  logic       consumed;
  logic       at_end;

  always_comb begin
    nxt      = cur;
    count    = 2'd0;
    ev[0]    = '{code: EV_NAME, ch: 8'h00, last: 1'b0};
    ev[1]    = '{code: EV_NAME, ch: 8'h00, last: 1'b0};
    p1       = run_pass(cur.pstate, in_byte);
    p2       = run_pass(p1.st, in_byte);
    fail     = 1'b0;
    consumed = (in_byte == CH_NUL);
    at_end   = consumed || in_last;

    if (cur.error_flag) begin
      fail = 1'b1;
    end else begin
      // Resolve the pending lookahead symbol first
      nxt.held = HELD_NONE;
      case (cur.held)
        HELD_LT: begin
          if (in_byte == CH_SLASH) begin
            nxt.pstate       = ST_END_WAIT;
            nxt.first_symbol = 1'b0;
            consumed         = 1'b1;
          end else if (in_byte == CH_QM) begin
            if (!cur.first_symbol) begin
              fail = 1'b1;
            end else begin
              nxt.first_symbol = 1'b0;
              nxt.in_prolog    = 1'b1;
              nxt.pstate       = ST_PI;
              consumed         = 1'b1;
            end
          end else begin
            nxt.first_symbol = 1'b0;
            nxt.pstate       = ST_TAG_WAIT;
          end
        end
        HELD_SLASH: begin
          if (in_byte != CH_GT) begin
            fail = 1'b1;
          end else begin
            ev[count[0]] = '{code: EV_EMPTY, ch: 8'h00, last: 1'b0};
            count        = count + 2'd1;
            nxt.pstate   = ST_TOP;
            consumed     = 1'b1;
          end
        end
        HELD_QM: begin
          if (in_byte == CH_GT) begin
            nxt.in_prolog = 1'b0;
            nxt.pstate    = ST_TOP;
            consumed      = 1'b1;
          end
        end
        default: ;
      endcase

      // Up to two passes: a name ends on a non-letter that is parsed again
      if (!fail && !consumed) begin
        p1         = run_pass(nxt.pstate, in_byte);
        p2         = run_pass(p1.st, in_byte);
        nxt.pstate = p1.st;
        nxt.held   = p1.held;
        if (p1.fail) begin
          fail = 1'b1;
        end else if (p1.ev) begin
          ev[count[0]] = '{code: p1.code, ch: p1.ch, last: 1'b0};
          count        = count + 2'd1;
        end
        if (!p1.fail && p1.again) begin
          nxt.pstate = p2.st;
          nxt.held   = p2.held;
          if (p2.fail) begin
            fail = 1'b1;
          end else if (p2.ev) begin
            ev[count[0]] = '{code: p2.code, ch: p2.ch, last: 1'b0};
            count        = count + 2'd1;
          end
        end
      end

      if (!fail && at_end) begin
        if (nxt.pstate == ST_TOP && nxt.held == HELD_NONE && !nxt.in_prolog) begin
          ev[count[0]]     = '{code: EV_INEND, ch: 8'h00, last: 1'b0};
          count            = count + 2'd1;
          nxt.first_symbol = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      nxt.error_flag = 1'b1;
      ev[count[0]]   = '{code: EV_ERROR, ch: 8'h00, last: 1'b0};
      count          = count + 2'd1;
    end

    // Flag the final result of this item
    if (count == 2'd1) ev[0].last = 1'b1;
    if (count == 2'd2) ev[1].last = 1'b1;
  end

  assign r0 = ev[0];
  assign r1 = ev[1];

endmodule

// ===== rtl/xtok_queue.sv =====
// ----------------------------------------------------------------------------
// xtok_queue: result queue
// Takes up to two results per cycle, hands one per cycle out unless stalled.
// ----------------------------------------------------------------------------
module xtok_queue
  import xtok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output result_t    head
);

  result_t             entry [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic [QCNT_W-1:0]   count_next;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entry[rd_ptr];
  // Two free slots are needed before the next item may enter
  assign room      = (count <= QCNT_W'(QDEPTH - 2));

  assign count_next = count + QCNT_W'(push_count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entry[wr_ptr] <= push0;
    if (push_count == 2'd2) entry[wr_ptr + QPTR_W'(1)] <= push1;
  end

endmodule

// ===== rtl/xml_tag_stream_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// xml_tag_stream_tokenizer_top: streaming XML tag tokenizer
// Byte-wide tag grammar recognizer producing classified character and node
// events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one document byte per item, with
//   in_last marking the final byte. A zero byte also ends the document.
//   Output channel (out_valid / out_stall): zero, one or two result items per
//   input item, in order; out_last marks the final result of an input item.
//   Items that produce no result (skipped whitespace, prolog bytes) emit
//   nothing.
//   An accepted item passes through the input register, then the transition
//   logic into the result queue. Throughput: one input item per cycle while
//   out_stall is low and each item yields at most one result; items yielding
//   two results are paced by the single output port. The input stalls while
//   the result queue has fewer than two free slots.
//   Reset clears the input register, the queue and the parser to its
//   document-start position. A stalled receiver holds the head result stable;
//   the queue then fills and backs up into the input.
//   After a grammar fault every further item yields one error event until
//   reset.
// ----------------------------------------------------------------------------
module xml_tag_stream_tokenizer_top
  import xtok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] event_res,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  // Parser state
  tok_state_t st;
  tok_state_t st_next;

  logic       room;
  logic       advance;
  logic [1:0] step_count;
  logic [1:0] push_count;
  result_t    r0;
  result_t    r1;
  result_t    head;

  // Advance the held byte once the queue can absorb both possible results
  assign advance  = hold_valid && room;
  assign in_stall = hold_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= in_byte;
      hold_last <= in_last;
    end
  end

  xtok_step u_step (
    .cur     (st),
    .in_byte (hold_byte),
    .in_last (hold_last),
    .nxt     (st_next),
    .count   (step_count),
    .r0      (r0),
    .r1      (r1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{pstate: ST_TOP, held: HELD_NONE, in_prolog: 1'b0,
              error_flag: 1'b0, first_symbol: 1'b1};
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign push_count = advance ? step_count : 2'd0;

  xtok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (r0),
    .push1      (r1),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  assign event_res = head.code;
  assign out_byte  = head.ch;
  assign out_last  = head.last;

endmodule

// ===== rtl/xtok_checker.sv =====
// ----------------------------------------------------------------------------
// xtok_checker: port-level checks of the tag tokenizer
// Watches the top-level ports and flags event formatting or reset slips.
// ----------------------------------------------------------------------------
module xtok_checker
  import xtok_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] event_res,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(out_byte)
      && $stable(out_last))
    else $error("stalled result changed");

  // Drop all pending results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // Carry no character on marker events
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_NAME && event_res != EV_ANAME && event_res != EV_VALUE
      |-> out_byte == 8'h00)
    else $error("marker event carries a character");

  // Close every item on an error or input-end event
  a_final_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_ERROR || event_res == EV_INEND) |-> out_last)
    else $error("error or input end not final in item");

  // Raise input stall only while results are waiting in the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_valid |-> 1'b0)
    else $error("input stalled with no result waiting");

endmodule

bind xml_tag_stream_tokenizer_top xtok_checker u_xtok_checker (.*);

// ===== tb/xml_tag_stream_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_tag_stream_tokenizer_top_tb: self-checking bench for the tag tokenizer
// Walks a short table of directed bytes, then streams random well-formed
// documents (prologs, nested start/end/empty tags, attributes, blanks) and
// ends with one random grammar fault followed by noise. A local tag grammar
// tracker predicts the results the table omits; output is checked in order.
// ----------------------------------------------------------------------------
module xml_tag_stream_tokenizer_top_tb;
  import xtok_pkg::*;

  localparam int RAND_ITEMS = 1780;   // no new random document once this many bytes are sent
  localparam int PHASE_LEN  = 445;    // bytes per idling phase
  localparam int CYCLE_CAP  = 400000;

  // Idling pattern of the two channels
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_t;

  // Grammar faults injected at the very end (the error is sticky)
  typedef enum logic [3:0] {
    FK_TEXT,
    FK_LATE_PROLOG,
    FK_SLASH,
    FK_NO_NAME,
    FK_NO_EQ,
    FK_NO_VALUE,
    FK_OPEN_END,
    FK_NUL_IN_VALUE,
    FK_SYMBOL,
    FK_PROLOG_END
  } fault_kind_t;

  // One directed row; cnt < 0 means the tracker supplies the results
  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    int         cnt;
    event_t     e0;
    logic [7:0] c0;
    event_t     e1;
    logic [7:0] c1;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] event_res;
  logic [7:0] out_byte;
  logic       out_last;

  // Tag grammar tracker state
  pstate_t tk_pos;
  held_t   tk_held;
  logic    tk_prolog;
  logic    tk_err;
  logic    tk_first;

  result_t    item_events[$];   // events caused by the current byte
  result_t    pending_events[$]; // events still owed by the block
  dir_row_t   dir_rows[$];
  logic [7:0] doc_q[$];
  logic       last_q[$];

  idle_mode_t mode = IDLE_NONE;
  int         mismatches = 0;
  int         parsed_items = 0;
  int         cycles = 0;

  xml_tag_stream_tokenizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Tag grammar tracker
  // --------------------------------------------------------------------------
  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic ws_char(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void emit(event_t code, logic [7:0] c);
    result_t r;
    r.code = code;
    r.ch   = c;
    r.last = 1'b0;
    item_events.insert(item_events.size(), r);
  endfunction

  // Latch the sticky error and report it
  function automatic void fault();
    tk_err = 1'b1;
    emit(EV_ERROR, 8'h00);
  endfunction

  // Advance the tracker by one byte; the events land in item_events
  function automatic void tokenize(logic [7:0] b, logic lst);
    logic at_end;
    logic done;
    at_end = (b == CH_NUL) || lst;
    done   = (b == CH_NUL);
    item_events.delete();
    if (tk_err) begin
      fault();
      return;
    end

    // Resolve the pending lookahead symbol first
    case (tk_held)
      HELD_LT: begin
        tk_held = HELD_NONE;
        if (b == CH_SLASH) begin
          tk_pos   = ST_END_WAIT;
          tk_first = 1'b0;
          done     = 1'b1;
        end else if (b == CH_QM) begin
          if (!tk_first) begin
            fault();
            return;
          end
          tk_first  = 1'b0;
          tk_prolog = 1'b1;
          tk_pos    = ST_PI;
          done      = 1'b1;
        end else begin
          tk_first = 1'b0;
          tk_pos   = ST_TAG_WAIT;
        end
      end
      HELD_SLASH: begin
        tk_held = HELD_NONE;
        if (b != CH_GT) begin
          fault();
          return;
        end
        emit(EV_EMPTY, 8'h00);
        tk_pos = ST_TOP;
        done   = 1'b1;
      end
      HELD_QM: begin
        tk_held = HELD_NONE;
        if (b == CH_GT) begin
          tk_prolog = 1'b0;
          tk_pos    = ST_TOP;
          done      = 1'b1;
        end
      end
      default: ;
    endcase

    // A name ends at the first non-letter, which is parsed again
    for (int pass = 0; pass < 2 && !done; pass++) begin
      done = 1'b1;
      case (tk_pos)
        ST_TOP: begin
          if (b == CH_LT) tk_held = HELD_LT;
          else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_TAG_WAIT, ST_END_WAIT: begin
          if (alpha_ch(b)) begin
            emit(EV_NAME, b);
            tk_pos = (tk_pos == ST_TAG_WAIT) ? ST_TAG_NAME : ST_END_NAME;
          end else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_TAG_NAME, ST_END_NAME: begin
          if (alpha_ch(b)) emit(EV_NAME, b);
          else begin
            tk_pos = (tk_pos == ST_TAG_NAME) ? ST_ATTR_WAIT : ST_CLOSE_WAIT;
            done   = 1'b0;
          end
        end
        ST_ATTR_WAIT: begin
          if (alpha_ch(b)) begin
            emit(EV_ANAME, b);
            tk_pos = ST_ATTR_NAME;
          end else if (b == CH_GT) begin
            emit(EV_START, 8'h00);
            tk_pos = ST_TOP;
          end else if (b == CH_SLASH) begin
            tk_held = HELD_SLASH;
          end else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_ATTR_NAME: begin
          if (alpha_ch(b)) emit(EV_ANAME, b);
          else begin
            tk_pos = ST_EQ_WAIT;
            done   = 1'b0;
          end
        end
        ST_EQ_WAIT: begin
          if (b == CH_EQ) tk_pos = ST_VAL_WAIT;
          else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_VAL_WAIT: begin
          if (b == CH_QUOTE) tk_pos = ST_VAL;
          else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_VAL: begin
          if (b == CH_QUOTE) begin
            emit(EV_ADONE, 8'h00);
            tk_pos = ST_ATTR_WAIT;
          end else begin
            emit(EV_VALUE, b);
          end
        end
        ST_CLOSE_WAIT: begin
          if (b == CH_GT) begin
            emit(EV_END, 8'h00);
            tk_pos = ST_TOP;
          end else if (!ws_char(b)) begin
            fault();
            return;
          end
        end
        ST_PI: begin
          if (b == CH_QUOTE) tk_pos = ST_PI_QUOTE;
          else if (b == CH_QM) tk_held = HELD_QM;
        end
        ST_PI_QUOTE: begin
          if (b == CH_QUOTE) tk_pos = ST_PI;
        end
        default: begin
          fault();
          return;
        end
      endcase
    end

    // Input end is clean only at top level with nothing open
    if (at_end) begin
      if (tk_pos == ST_TOP && tk_held == HELD_NONE && !tk_prolog) begin
        emit(EV_INEND, 8'h00);
        tk_first = 1'b1;
      end else begin
        fault();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Document builder
  // --------------------------------------------------------------------------
  function automatic void put(logic [7:0] b);
    doc_q.insert(doc_q.size(), b);
    last_q.insert(last_q.size(), 1'b0);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return ($urandom_range(1) != 0) ? 8'h41 + c : 8'h61 + c;
  endfunction

  function automatic logic [7:0] rand_blank();
    logic [7:0] c;
    c = 8'($urandom_range(5));
    return (c == 8'd5) ? CH_SPACE : CH_TAB + c;
  endfunction

  function automatic void add_blanks(int maxn);
    repeat ($urandom_range(maxn)) put(rand_blank());
  endfunction

  // Any byte but NUL and the closing quote
  function automatic logic [7:0] value_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(1, 255)); while (v == CH_QUOTE);
    return v;
  endfunction

  // <? ... ?> with quoted stretches that may hold a false closer
  function automatic void add_prolog();
    logic [7:0] v;
    put(CH_LT);
    put(CH_QM);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(3) == 0) begin
        put(CH_QUOTE);
        if ($urandom_range(1) != 0) begin
          put(CH_QM);
          put(CH_GT);
        end
        repeat ($urandom_range(3)) put(value_byte());
        put(CH_QUOTE);
      end else begin
        do v = 8'($urandom_range(1, 255)); while (v == CH_QUOTE || v == CH_GT);
        put(v);
      end
    end
    put(CH_QM);
    put(CH_GT);
  endfunction

  // A run of nested and sibling tags, all closed at the end
  function automatic void add_tags();
    logic [31:0] open_nm[$];
    int          open_len[$];
    logic [31:0] nm;
    int          len;
    int          steps;
    steps = $urandom_range(1, 6);
    for (int s = 0; s < steps || open_nm.size() != 0; s++) begin
      add_blanks(2);
      if (open_nm.size() != 0 &&
          (s >= steps || open_nm.size() == 3 || $urandom_range(2) == 0)) begin
        nm  = open_nm.pop_back();
        len = open_len.pop_back();
        put(CH_LT);
        put(CH_SLASH);
        add_blanks(1);
        for (int k = 0; k < len; k++) put(nm[8*k +: 8]);
        add_blanks(1);
        put(CH_GT);
      end else begin
        nm  = '0;
        len = $urandom_range(1, 4);
        put(CH_LT);
        add_blanks(1);
        for (int k = 0; k < len; k++) begin
          nm[8*k +: 8] = rand_letter();
          put(nm[8*k +: 8]);
        end
        repeat ($urandom_range(2)) begin
          put(rand_blank());
          add_blanks(1);
          repeat ($urandom_range(1, 3)) put(rand_letter());
          add_blanks(1);
          put(CH_EQ);
          add_blanks(1);
          put(CH_QUOTE);
          repeat ($urandom_range(5)) put(value_byte());
          put(CH_QUOTE);
        end
        if ($urandom_range(2) == 0) begin
          add_blanks(1);
          put(CH_SLASH);
          put(CH_GT);
        end else begin
          put(CH_GT);
          open_nm.insert(open_nm.size(), nm);
          open_len.insert(open_len.size(), len);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic logic src_gap();
    case (mode)
      IDLE_SRC:  return $urandom_range(99) < 56;
      IDLE_BOTH: return $urandom_range(99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  // Offer one item at the falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (src_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    parsed_items++;
  endtask

  // Send, then queue the predicted events with the last mark on the final one
  task automatic feed(input logic [7:0] b, input logic lst);
    send_byte(b, lst);
    tokenize(b, lst);
    if (item_events.size() != 0) item_events[item_events.size() - 1].last = 1'b1;
    foreach (item_events[i]) pending_events.insert(pending_events.size(), item_events[i]);
  endtask

  task automatic play_doc();
    foreach (doc_q[i]) feed(doc_q[i], last_q[i]);
  endtask

  // Hold off the sender until the block has delivered everything
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic void add_row(logic [7:0] b, logic lst = 1'b0, int cnt = -1,
                                  event_t e0 = EV_NAME, logic [7:0] c0 = 8'h00,
                                  event_t e1 = EV_NAME, logic [7:0] c1 = 8'h00);
    dir_row_t r;
    r.b   = b;
    r.lst = lst;
    r.cnt = cnt;
    r.e0  = e0;
    r.c0  = c0;
    r.e1  = e1;
    r.c1  = c1;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall and in-order check
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    case (mode)
      IDLE_SINK: out_stall <= $urandom_range(99) < 56;
      IDLE_BOTH: out_stall <= $urandom_range(99) < 23;
      default:   out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, got event %0d byte %02h last %0b",
                 $time, event_res, out_byte, out_last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (event_res !== want.code) begin
          $display("%0t: event mismatch: expected %0d, got %0d", $time, want.code, event_res);
          mismatches++;
        end
        if (out_byte !== want.ch) begin
          $display("%0t: byte mismatch: expected %02h, got %02h", $time, want.ch, out_byte);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, out_last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    result_t     r;
    idle_mode_t  nxt;
    fault_kind_t kind;

    // Tracker starts at the reset position
    tk_pos    = ST_TOP;
    tk_held   = HELD_NONE;
    tk_prolog = 1'b0;
    tk_err    = 1'b0;
    tk_first  = 1'b1;

    // Empty document right after reset
    add_row(CH_NUL, 1'b0, 1, EV_INEND);
    // Prolog with a quoted false closer
    add_row(CH_LT);
    add_row(CH_QM);
    add_row(CH_QUOTE);
    add_row(CH_QM);
    add_row(CH_GT);
    add_row(CH_QUOTE);
    add_row(CH_QM);
    add_row(CH_GT);
    // <A b="\xFF\x01"> : lowest letter, extreme value bytes
    add_row(CH_LT);
    add_row("A", 1'b0, 1, EV_NAME, "A");
    add_row(CH_TAB);
    add_row("b");
    add_row(CH_EQ);
    add_row(CH_QUOTE);
    add_row(8'hFF, 1'b0, 1, EV_VALUE, 8'hFF);
    add_row(8'h01);
    add_row(CH_QUOTE, 1'b0, 1, EV_ADONE);
    add_row(CH_GT, 1'b0, 1, EV_START);
    // <z/> right after '>', name ended by the slash
    add_row(CH_LT);
    add_row("z", 1'b0, 1, EV_NAME, "z");
    add_row(CH_SLASH);
    add_row(CH_GT, 1'b0, 1, EV_EMPTY);
    // </z> with the last flag on the closer: node end, then input end
    add_row(CH_LT);
    add_row(CH_SLASH);
    add_row("z");
    add_row(CH_GT, 1'b1, 2, EV_END, 8'h00, EV_INEND);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].lst);
      tokenize(dir_rows[i].b, dir_rows[i].lst);
      if (dir_rows[i].cnt < 0) begin
        if (item_events.size() != 0) item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[k]) pending_events.insert(pending_events.size(), item_events[k]);
      end else begin
        r.code = dir_rows[i].e0;
        r.ch   = dir_rows[i].c0;
        r.last = (dir_rows[i].cnt == 1);
        pending_events.insert(pending_events.size(), r);
        if (dir_rows[i].cnt == 2) begin
          r.code = dir_rows[i].e1;
          r.ch   = dir_rows[i].c1;
          r.last = 1'b1;
          pending_events.insert(pending_events.size(), r);
        end
      end
    end

    // Random well-formed documents; drain fully at every change of idling
    while (parsed_items < RAND_ITEMS) begin
      nxt = idle_mode_t'((parsed_items / PHASE_LEN) % 4);
      if (nxt != mode) begin
        settle();
        mode = nxt;
      end
      doc_q.delete();
      last_q.delete();
      if ($urandom_range(2) == 0) add_prolog();
      if ($urandom_range(11) != 0) add_tags();
      add_blanks(2);
      case ($urandom_range(3))
        0: put(CH_NUL);
        1: begin
          put(CH_NUL);
          last_q[last_q.size() - 1] = 1'b1;
        end
        default: begin
          if (doc_q.size() == 0) put(CH_NUL);
          else last_q[last_q.size() - 1] = 1'b1;
        end
      endcase
      play_doc();
    end

    // One grammar fault, then noise; the error sticks from here on
    settle();
    mode = IDLE_BOTH;
    doc_q.delete();
    last_q.delete();
    kind = fault_kind_t'($urandom_range(9));
    case (kind)
      FK_TEXT: put(rand_letter());
      FK_LATE_PROLOG: begin
        put(CH_LT);
        put("a");
        put(CH_SLASH);
        put(CH_GT);
        put(CH_LT);
        put(CH_QM);
      end
      FK_SLASH: begin
        put(CH_LT);
        put("a");
        put(CH_SLASH);
        put(CH_SPACE);
      end
      FK_NO_NAME: begin
        put(CH_LT);
        put(CH_GT);
      end
      FK_NO_EQ: begin
        put(CH_LT);
        put("a");
        put(CH_SPACE);
        put("b");
        put(CH_SPACE);
        put(CH_QUOTE);
      end
      FK_NO_VALUE: begin
        put(CH_LT);
        put("a");
        put(CH_SPACE);
        put("b");
        put(CH_EQ);
        put("x");
      end
      FK_OPEN_END: begin
        put(CH_LT);
        put("a");
        last_q[last_q.size() - 1] = 1'b1;
      end
      FK_NUL_IN_VALUE: begin
        put(CH_LT);
        put("a");
        put(CH_SPACE);
        put("b");
        put(CH_EQ);
        put(CH_QUOTE);
        put("x");
        put(CH_NUL);
      end
      FK_SYMBOL: begin
        put(CH_LT);
        put("a");
        put(CH_SPACE);
        put(8'h3B);
      end
      default: begin
        put(CH_LT);
        put(CH_QM);
        put("x");
        last_q[last_q.size() - 1] = 1'b1;
      end
    endcase
    play_doc();
    repeat (40) feed(8'($urandom_range(255)), 1'($urandom_range(1)));

    // Drain, then leave room for anything the block should not send
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xtok_pkg.sv
rtl/xtok_step.sv
rtl/xtok_queue.sv
rtl/xml_tag_stream_tokenizer_top.sv
rtl/xtok_checker.sv
tb/xml_tag_stream_tokenizer_top_tb.sv
